// ----- src/speed_heart_rate_statistics_core_defines.svh -----
// Assertion macros shared by the ride statistics RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef SPEED_HEART_RATE_STATISTICS_CORE_DEFINES_SVH
`define SPEED_HEART_RATE_STATISTICS_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SHRS_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SHRS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/shrs_pkg.sv -----
// Shared widths, codes and types for the ride statistics core.
// No dependencies; used by every module of the block.
`default_nettype none

package shrs_pkg;

    // accumulator widths
    localparam int TIME_SUM_BITS    = 40;
    localparam int PRODUCT_SUM_BITS = 56;

    // field widths
    localparam int ACTION_W    = 2;
    localparam int SPEED_IN_W  = 16;
    localparam int SPEED_W     = 15;
    localparam int INTERVAL_W  = 16;
    localparam int BPM_W       = 8;
    localparam int HR_TOTAL_W  = 40;
    localparam int COUNT_W     = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 15;

    // derived
    localparam int PRODUCT_W = SPEED_W + INTERVAL_W;
    localparam int HR_NUM_W  = HR_TOTAL_W + 1;
    localparam int DIV_STEPS = (PRODUCT_SUM_BITS > HR_NUM_W) ? PRODUCT_SUM_BITS : HR_NUM_W;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);

    // front-to-back queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // register reset values
    localparam logic [SPEED_W-1:0] SPEED_LIMIT_RST   = 15'd12000;
    localparam logic [SPEED_W-1:0] MOVE_THRESH_RST   = 15'd300;
    localparam logic [BPM_W-1:0]   HR_LOW_RST        = 8'd30;
    localparam logic [BPM_W-1:0]   HR_HIGH_RST       = 8'd240;

    typedef enum logic [ACTION_W-1:0] {
        ACT_SPEED = 2'd0,
        ACT_HEART = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NOP   = 2'd3
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPEED_LIMIT  = 2'd0,
        CFG_MOVE_THRESH  = 2'd1,
        CFG_HR_LOW       = 2'd2,
        CFG_HR_HIGH      = 2'd3
    } cfg_reg_t;

    // classified operation handed from front to back
    typedef enum logic [2:0] {
        OP_NONE,
        OP_SPEED,
        OP_MOVE,
        OP_HEART,
        OP_CLEAR
    } op_kind_t;

    typedef struct packed {
        op_kind_t                kind;
        logic                    accepted;
        logic [SPEED_W-1:0]      speed;
        logic [INTERVAL_W-1:0]   interval;
        logic [BPM_W-1:0]        bpm;
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_UPDATE,
        ST_LOAD,
        ST_DIV,
        ST_DONE
    } back_state_t;

endpackage

`default_nettype wire

// ----- src/shrs_front.sv -----
// Front end: configuration registers, input handshake and sample classification.
// Depends on shrs_pkg.
`default_nettype none

module shrs_front (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [shrs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [shrs_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [shrs_pkg::ACTION_W-1:0]    s_action,
    input  wire logic signed [shrs_pkg::SPEED_IN_W-1:0] s_speed_sample,
    input  wire logic [shrs_pkg::INTERVAL_W-1:0]  s_interval_ms,
    input  wire logic [shrs_pkg::BPM_W-1:0]       s_heart_rate_sample,
    input  wire logic                             q_full,
    output logic                                  push,
    output shrs_pkg::op_t                         push_op
);

    logic [shrs_pkg::SPEED_W-1:0] speed_limit_reg;
    logic [shrs_pkg::SPEED_W-1:0] move_thresh_reg;
    logic [shrs_pkg::BPM_W-1:0]   hr_low_reg;
    logic [shrs_pkg::BPM_W-1:0]   hr_high_reg;

    logic [shrs_pkg::SPEED_W-1:0] speed_mag;
    logic                         speed_ok;
    logic                         heart_ok;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_limit_reg <= shrs_pkg::SPEED_LIMIT_RST;
            move_thresh_reg <= shrs_pkg::MOVE_THRESH_RST;
            hr_low_reg      <= shrs_pkg::HR_LOW_RST;
            hr_high_reg     <= shrs_pkg::HR_HIGH_RST;
        end else if (cfg_valid) begin
            case (shrs_pkg::cfg_reg_t'(cfg_index))
                shrs_pkg::CFG_SPEED_LIMIT: speed_limit_reg <= cfg_data;
                shrs_pkg::CFG_MOVE_THRESH: move_thresh_reg <= cfg_data;
                shrs_pkg::CFG_HR_LOW:      hr_low_reg  <= cfg_data[shrs_pkg::BPM_W-1:0];
                shrs_pkg::CFG_HR_HIGH:     hr_high_reg <= cfg_data[shrs_pkg::BPM_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_ready = !q_full;
    assign push    = s_valid && !q_full;

    assign speed_mag = s_speed_sample[shrs_pkg::SPEED_W-1:0];
    assign speed_ok  = (s_interval_ms != '0) && !s_speed_sample[shrs_pkg::SPEED_IN_W-1]
                       && (speed_mag <= speed_limit_reg);
    // an inverted band rejects everything by construction
    assign heart_ok  = (s_heart_rate_sample >= hr_low_reg)
                       && (s_heart_rate_sample <= hr_high_reg);

    always_comb begin
        push_op          = '0;
        push_op.kind     = shrs_pkg::OP_NONE;
        push_op.speed    = speed_mag;
        push_op.interval = s_interval_ms;
        push_op.bpm      = s_heart_rate_sample;
        case (shrs_pkg::action_t'(s_action))
            shrs_pkg::ACT_SPEED: begin
                if (speed_ok) begin
                    push_op.accepted = 1'b1;
                    push_op.kind     = (speed_mag >= move_thresh_reg) ? shrs_pkg::OP_MOVE
                                                                      : shrs_pkg::OP_SPEED;
                end
            end
            shrs_pkg::ACT_HEART: begin
                if (heart_ok) begin
                    push_op.accepted = 1'b1;
                    push_op.kind     = shrs_pkg::OP_HEART;
                end
            end
            shrs_pkg::ACT_CLEAR: push_op.kind = shrs_pkg::OP_CLEAR;
            default:             push_op.kind = shrs_pkg::OP_NONE;
        endcase
    end

endmodule

`default_nettype wire

// ----- src/shrs_queue.sv -----
// Short FIFO of classified operations between front and back end.
// Depends on shrs_pkg.
`default_nettype none

module shrs_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire shrs_pkg::op_t push_op,
    output logic               full,
    input  wire logic          pop,
    output logic               head_valid,
    output shrs_pkg::op_t      head_op
);

    shrs_pkg::op_t                  entries_reg [shrs_pkg::QUEUE_DEPTH];
    logic [shrs_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [shrs_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [shrs_pkg::QCNT_W-1:0]    count_reg,  count_next;

    assign full       = (count_reg == shrs_pkg::QCNT_W'(shrs_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_op    = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == shrs_pkg::QPTR_W'(shrs_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == shrs_pkg::QPTR_W'(shrs_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

// ----- src/shrs_back.sv -----
// Back end: statistics accumulators, bit-serial dividers for both means, result register.
// Depends on shrs_pkg and the assertion macro header.
`default_nettype none
`include "speed_heart_rate_statistics_core_defines.svh"

module shrs_back (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           head_valid,
    input  wire shrs_pkg::op_t                  head_op,
    output logic                                pop,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic                                m_sample_accepted,
    output logic [shrs_pkg::SPEED_W-1:0]        m_peak_speed,
    output logic [shrs_pkg::SPEED_W-1:0]        m_mean_moving_speed,
    output logic [shrs_pkg::BPM_W-1:0]          m_peak_heart_rate,
    output logic [shrs_pkg::BPM_W-1:0]          m_mean_heart_rate
);

    localparam int TW = shrs_pkg::TIME_SUM_BITS;
    localparam int PW = shrs_pkg::PRODUCT_SUM_BITS;
    localparam int CW = shrs_pkg::COUNT_W;
    localparam int DW = shrs_pkg::DIV_STEPS;

    shrs_pkg::back_state_t state_reg, state_next;
    shrs_pkg::op_t         op_reg, op_next;
    logic [shrs_pkg::PRODUCT_W-1:0] prod_reg, prod_next;

    // statistics
    logic [shrs_pkg::SPEED_W-1:0]    max_speed_reg, max_speed_next;
    logic [TW-1:0]                   time_sum_reg,  time_sum_next;
    logic [PW-1:0]                   prod_sum_reg,  prod_sum_next;
    logic [shrs_pkg::BPM_W-1:0]      max_hr_reg,    max_hr_next;
    logic [shrs_pkg::HR_TOTAL_W-1:0] hr_total_reg,  hr_total_next;
    logic [CW-1:0]                   hr_count_reg,  hr_count_next;

    // dividers
    logic [DW-1:0]                   s_num_reg, s_num_next;
    logic [TW-1:0]                   s_rem_reg, s_rem_next;
    logic [shrs_pkg::SPEED_W-1:0]    s_quo_reg, s_quo_next;
    logic                            s_ovf_reg, s_ovf_next;
    logic [DW-1:0]                   h_num_reg, h_num_next;
    logic [CW-1:0]                   h_rem_reg, h_rem_next;
    logic [shrs_pkg::BPM_W-1:0]      h_quo_reg, h_quo_next;
    logic                            h_ovf_reg, h_ovf_next;
    logic [shrs_pkg::STEP_W-1:0]     step_reg,  step_next;

    // result register
    logic                            m_valid_reg, m_valid_next;
    logic                            acc_out_reg, acc_out_next;
    logic [shrs_pkg::SPEED_W-1:0]    pk_spd_out_reg, pk_spd_out_next;
    logic [shrs_pkg::SPEED_W-1:0]    mn_spd_out_reg, mn_spd_out_next;
    logic [shrs_pkg::BPM_W-1:0]      pk_hr_out_reg,  pk_hr_out_next;
    logic [shrs_pkg::BPM_W-1:0]      mn_hr_out_reg,  mn_hr_out_next;

    // datapath temporaries
    logic [TW:0]                     time_add;
    logic [PW:0]                     prod_add;
    logic [TW:0]                     s_trial;
    logic                            s_ge;
    logic [TW:0]                     s_diff;
    logic [CW:0]                     h_trial;
    logic                            h_ge;
    logic [CW:0]                     h_diff;
    logic [shrs_pkg::HR_NUM_W-1:0]   hr_num;

    assign time_add = {1'b0, time_sum_reg} + (TW+1)'(op_reg.interval);
    assign prod_add = {1'b0, prod_sum_reg} + (PW+1)'(prod_reg);
    assign hr_num   = {1'b0, hr_total_reg} + shrs_pkg::HR_NUM_W'(hr_count_reg >> 1);

    // one restoring step per cycle for each quotient
    assign s_trial = {s_rem_reg, s_num_reg[DW-1]};
    assign s_ge    = (s_trial >= {1'b0, time_sum_reg});
    assign s_diff  = s_trial - {1'b0, time_sum_reg};
    assign h_trial = {h_rem_reg, h_num_reg[DW-1]};
    assign h_ge    = (h_trial >= {1'b0, hr_count_reg});
    assign h_diff  = h_trial - {1'b0, hr_count_reg};

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        prod_next       = prod_reg;
        max_speed_next  = max_speed_reg;
        time_sum_next   = time_sum_reg;
        prod_sum_next   = prod_sum_reg;
        max_hr_next     = max_hr_reg;
        hr_total_next   = hr_total_reg;
        hr_count_next   = hr_count_reg;
        s_num_next      = s_num_reg;
        s_rem_next      = s_rem_reg;
        s_quo_next      = s_quo_reg;
        s_ovf_next      = s_ovf_reg;
        h_num_next      = h_num_reg;
        h_rem_next      = h_rem_reg;
        h_quo_next      = h_quo_reg;
        h_ovf_next      = h_ovf_reg;
        step_next       = step_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        acc_out_next    = acc_out_reg;
        pk_spd_out_next = pk_spd_out_reg;
        mn_spd_out_next = mn_spd_out_reg;
        pk_hr_out_next  = pk_hr_out_reg;
        mn_hr_out_next  = mn_hr_out_reg;
        pop             = 1'b0;

        case (state_reg)
            shrs_pkg::ST_IDLE: begin
                if (head_valid) begin
                    pop        = 1'b1;
                    op_next    = head_op;
                    state_next = shrs_pkg::ST_MUL;
                end
            end
            shrs_pkg::ST_MUL: begin
                prod_next  = shrs_pkg::PRODUCT_W'(op_reg.speed)
                             * shrs_pkg::PRODUCT_W'(op_reg.interval);
                state_next = shrs_pkg::ST_UPDATE;
            end
            shrs_pkg::ST_UPDATE: begin
                case (op_reg.kind)
                    shrs_pkg::OP_SPEED: begin
                        if (op_reg.speed > max_speed_reg) max_speed_next = op_reg.speed;
                    end
                    shrs_pkg::OP_MOVE: begin
                        if (op_reg.speed > max_speed_reg) max_speed_next = op_reg.speed;
                        time_sum_next = time_add[TW] ? '1 : time_add[TW-1:0];
                        prod_sum_next = prod_add[PW] ? '1 : prod_add[PW-1:0];
                    end
                    shrs_pkg::OP_HEART: begin
                        if (op_reg.bpm > max_hr_reg) max_hr_next = op_reg.bpm;
                        // count stuck at all ones: only the peak moves
                        if (hr_count_reg != '1) begin
                            hr_total_next = hr_total_reg
                                            + shrs_pkg::HR_TOTAL_W'(op_reg.bpm);
                            hr_count_next = hr_count_reg + 1'b1;
                        end
                    end
                    shrs_pkg::OP_CLEAR: begin
                        max_speed_next = '0;
                        time_sum_next  = '0;
                        prod_sum_next  = '0;
                        max_hr_next    = '0;
                        hr_total_next  = '0;
                        hr_count_next  = '0;
                    end
                    default: ;
                endcase
                state_next = shrs_pkg::ST_LOAD;
            end
            shrs_pkg::ST_LOAD: begin
                s_num_next = DW'(prod_sum_reg);
                s_rem_next = '0;
                s_quo_next = '0;
                s_ovf_next = 1'b0;
                h_num_next = DW'(hr_num);
                h_rem_next = '0;
                h_quo_next = '0;
                h_ovf_next = 1'b0;
                step_next  = '0;
                state_next = shrs_pkg::ST_DIV;
            end
            shrs_pkg::ST_DIV: begin
                s_num_next = {s_num_reg[DW-2:0], 1'b0};
                s_rem_next = s_ge ? s_diff[TW-1:0] : s_trial[TW-1:0];
                s_ovf_next = s_ovf_reg | s_quo_reg[shrs_pkg::SPEED_W-1];
                s_quo_next = {s_quo_reg[shrs_pkg::SPEED_W-2:0], s_ge};
                h_num_next = {h_num_reg[DW-2:0], 1'b0};
                h_rem_next = h_ge ? h_diff[CW-1:0] : h_trial[CW-1:0];
                h_ovf_next = h_ovf_reg | h_quo_reg[shrs_pkg::BPM_W-1];
                h_quo_next = {h_quo_reg[shrs_pkg::BPM_W-2:0], h_ge};
                step_next  = step_reg + 1'b1;
                if (step_reg == shrs_pkg::STEP_W'(DW - 1)) begin
                    state_next = shrs_pkg::ST_DONE;
                end
            end
            shrs_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    acc_out_next    = op_reg.accepted;
                    pk_spd_out_next = max_speed_reg;
                    pk_hr_out_next  = max_hr_reg;
                    if (time_sum_reg == '0)  mn_spd_out_next = '0;
                    else if (s_ovf_reg)      mn_spd_out_next = '1;
                    else                     mn_spd_out_next = s_quo_reg;
                    if (hr_count_reg == '0)  mn_hr_out_next = '0;
                    else if (h_ovf_reg)      mn_hr_out_next = '1;
                    else                     mn_hr_out_next = h_quo_reg;
                    state_next = shrs_pkg::ST_IDLE;
                end
            end
            default: state_next = shrs_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= shrs_pkg::ST_IDLE;
            m_valid_reg   <= 1'b0;
            max_speed_reg <= '0;
            time_sum_reg  <= '0;
            prod_sum_reg  <= '0;
            max_hr_reg    <= '0;
            hr_total_reg  <= '0;
            hr_count_reg  <= '0;
        end else begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            max_speed_reg <= max_speed_next;
            time_sum_reg  <= time_sum_next;
            prod_sum_reg  <= prod_sum_next;
            max_hr_reg    <= max_hr_next;
            hr_total_reg  <= hr_total_next;
            hr_count_reg  <= hr_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        prod_reg       <= prod_next;
        s_num_reg      <= s_num_next;
        s_rem_reg      <= s_rem_next;
        s_quo_reg      <= s_quo_next;
        s_ovf_reg      <= s_ovf_next;
        h_num_reg      <= h_num_next;
        h_rem_reg      <= h_rem_next;
        h_quo_reg      <= h_quo_next;
        h_ovf_reg      <= h_ovf_next;
        step_reg       <= step_next;
        acc_out_reg    <= acc_out_next;
        pk_spd_out_reg <= pk_spd_out_next;
        mn_spd_out_reg <= mn_spd_out_next;
        pk_hr_out_reg  <= pk_hr_out_next;
        mn_hr_out_reg  <= mn_hr_out_next;
    end

    assign m_valid             = m_valid_reg;
    assign m_sample_accepted   = acc_out_reg;
    assign m_peak_speed        = pk_spd_out_reg;
    assign m_mean_moving_speed = mn_spd_out_reg;
    assign m_peak_heart_rate   = pk_hr_out_reg;
    assign m_mean_heart_rate   = mn_hr_out_reg;

    `SHRS_ASSERT_IMPLIES(a_pop_only_idle, aclk, aresetn, pop, state_reg == shrs_pkg::ST_IDLE, "queue popped while back end busy")
    `SHRS_ASSERT_NEXT(a_pop_starts_op, aclk, aresetn, pop, state_reg == shrs_pkg::ST_MUL, "popped word did not start processing")
    `SHRS_ASSERT_IMPLIES(a_speed_rem_bound, aclk, aresetn, (state_reg == shrs_pkg::ST_DIV) && (time_sum_reg != '0), s_rem_reg < time_sum_reg, "speed divider remainder out of range")
    `SHRS_ASSERT_IMPLIES(a_hr_rem_bound, aclk, aresetn, (state_reg == shrs_pkg::ST_DIV) && (hr_count_reg != '0), h_rem_reg < hr_count_reg, "heart divider remainder out of range")
    `SHRS_ASSERT_IMPLIES(a_hr_mean_le_peak, aclk, aresetn, m_valid_reg, mn_hr_out_reg <= pk_hr_out_reg, "mean heart rate above peak")

endmodule

`default_nettype wire

// ----- src/speed_heart_rate_statistics_core.sv -----
// Ride statistics core: speed / heart-rate accumulators with mean outputs.
// Back end: one word at a time, paced by the bit-serial divider (56 steps).
// Input side keeps accepting into a 2-word queue while the back end works.
// Reset (aresetn low, synchronous): statistics cleared, config at defaults.
// Depends on shrs_pkg, shrs_front, shrs_queue, shrs_back.
`default_nettype none

module speed_heart_rate_statistics_core (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    // configuration write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [shrs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [shrs_pkg::CFG_DATA_W-1:0]   cfg_data,

    // sample input
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [shrs_pkg::ACTION_W-1:0]     s_action,
    input  wire logic signed [shrs_pkg::SPEED_IN_W-1:0] s_speed_sample,
    input  wire logic [shrs_pkg::INTERVAL_W-1:0]   s_interval_ms,
    input  wire logic [shrs_pkg::BPM_W-1:0]        s_heart_rate_sample,

    // statistics output
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_sample_accepted,
    output logic [shrs_pkg::SPEED_W-1:0]           m_peak_speed,
    output logic [shrs_pkg::SPEED_W-1:0]           m_mean_moving_speed,
    output logic [shrs_pkg::BPM_W-1:0]             m_peak_heart_rate,
    output logic [shrs_pkg::BPM_W-1:0]             m_mean_heart_rate
);

    // Front -> queue: each accepted word is classified up front against the
    // current thresholds, so the back end only sees an opcode plus operands.
    logic           q_full;
    logic           push;
    shrs_pkg::op_t  push_op;

    // Queue -> back
    logic           head_valid;
    shrs_pkg::op_t  head_op;
    logic           pop;

    // Front end owns the four config registers. They are read only while
    // classifying, so writes during idle take effect on the next word.
    shrs_front u_front (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_action            (s_action),
        .s_speed_sample      (s_speed_sample),
        .s_interval_ms       (s_interval_ms),
        .s_heart_rate_sample (s_heart_rate_sample),
        .q_full              (q_full),
        .push                (push),
        .push_op             (push_op)
    );

    // Decouples input handshake from the long-running back end.
    shrs_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_op    (push_op),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_op    (head_op)
    );

    // Back end sequence per word:
    //   pop -> multiply speed*interval -> update accumulators (saturating)
    //   -> load dividers -> 56 restoring steps -> write result register.
    // Mean speed = product sum / moving time (the 3.6 and ms scale cancel),
    // truncated and clamped to 15 bits. Mean heart rate is rounded half up
    // by adding count/2 to the total before dividing.
    shrs_back u_back (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .head_valid          (head_valid),
        .head_op             (head_op),
        .pop                 (pop),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_sample_accepted   (m_sample_accepted),
        .m_peak_speed        (m_peak_speed),
        .m_mean_moving_speed (m_mean_moving_speed),
        .m_peak_heart_rate   (m_peak_heart_rate),
        .m_mean_heart_rate   (m_mean_heart_rate)
    );

endmodule

`default_nettype wire
